>>> rtl/core/sws_pkg.sv
// Shared types and constants for the string wave stencil step block.
// Used by sws_ctrl, sws_datapath and string_wave_stencil_step.
package sws_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 24;
    localparam int PIDX_W     = 6;
    localparam int CC_W       = 26;
    localparam int NC_W       = 25;
    localparam int NP_W       = 7;
    localparam int NSUM_W     = DATA_W + 2;
    localparam int PROD_W     = NSUM_W + NC_W + 1;
    localparam int ACC_W      = PROD_W + 2;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 26;

    localparam logic [CC_W-1:0] CENTER_COEF_RST   = 26'd33541104;
    localparam logic [NC_W-1:0] NEIGHBOR_COEF_RST = 25'd6664;
    localparam logic [NP_W-1:0] NUM_POINTS_RST    = 7'd64;

    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_COEF   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NEIGHBOR_COEF = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_POINTS    = 2'd2;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STEP  = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RD,
        ST_SWEEP,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic             capture;
        logic             load_wr;
        logic             rd_issue;
        logic             sweep_issue;
        logic [CNT_W-1:0] sweep_idx;
        logic             out_load;
    } sws_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic sat;
    } sws_status_t;

endpackage

>>> rtl/core/sws_ctrl.sv
// Controller for the string wave stencil step block: sequences load, read and sweeps.
// Depends on sws_pkg.
module sws_ctrl
    import sws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  func_t       in_func,
    input  logic        out_free,
    input  sws_status_t status,
    output logic        s_tready,
    output sws_cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_func)
                        FUNC_LOAD:  state_next = ST_LOAD;
                        FUNC_READ:  state_next = ST_RD;
                        FUNC_START: state_next = ST_SWEEP;
                        FUNC_STEP:  state_next = ST_SWEEP;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:   state_next = ST_RESULT;
            ST_RD:     state_next = ST_RESULT;
            ST_SWEEP: begin
                if (idx_reg == CNT_W'(MAX_POINTS)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        idx_next = '0;
        if (state_reg == ST_SWEEP) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb begin
        s_tready         = (state_reg == ST_IDLE);
        cmd.capture      = (state_reg == ST_IDLE) && s_tvalid;
        cmd.load_wr      = (state_reg == ST_LOAD);
        cmd.rd_issue     = (state_reg == ST_RD);
        cmd.sweep_issue  = (state_reg == ST_SWEEP);
        cmd.sweep_idx    = idx_reg;
        cmd.out_load     = (state_reg == ST_RESULT) && out_free;
    end

`ifndef SYNTHESIS
    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !status.pipe_busy)
        else $error("pipeline busy while idle");

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result loaded into occupied output register");

    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep_issue |-> (cmd.sweep_idx <= CNT_W'(MAX_POINTS)))
        else $error("sweep index past grid");

    a_sweep_to_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.sweep_issue && (cmd.sweep_idx == CNT_W'(MAX_POINTS))) |=> (state_reg == ST_DRAIN))
        else $error("sweep did not end in drain");
`endif

endmodule

>>> rtl/core/sws_datapath.sv
// Datapath for the string wave stencil step block: shape memories, stencil pipeline,
// rounding and saturation. Depends on sws_pkg.
module sws_datapath
    import sws_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sws_cmd_t                 cmd,
    input  func_t                    in_func,
    input  logic [PIDX_W-1:0]        in_idx,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic [CC_W-1:0]          center_coef,
    input  logic [NC_W-1:0]          neighbor_coef,
    input  logic [NP_W-1:0]          num_points,
    output sws_status_t              status,
    output logic signed [DATA_W-1:0] res_value
);

    logic signed [DATA_W-1:0] cur_mem  [MAX_POINTS];
    logic signed [DATA_W-1:0] prev_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0]    cur_vld_reg, prev_vld_reg;

    func_t                    func_reg;
    logic [PIDX_W-1:0]        idx_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic                     idx_ok;
    logic                     half;
    logic [CNT_W-1:0]         n_eff;

    logic [ADDR_W-1:0]        rd_addr;
    logic                     rd_en;
    logic signed [DATA_W-1:0] cur_rd_reg, prev_rd_reg;
    logic                     cur_rd_vld_reg, prev_rd_vld_reg;

    logic                     cur_we;
    logic [ADDR_W-1:0]        cur_wa;
    logic signed [DATA_W-1:0] cur_wd;

    // stage 1: read data, window
    logic                     s1_v_reg;
    logic [CNT_W-1:0]         s1_j_reg;
    logic signed [DATA_W-1:0] rd_cur, rd_prev;
    logic signed [DATA_W-1:0] w1_reg, w2_reg, pv1_reg;
    logic [ADDR_W-1:0]        p1;
    logic                     int1;

    // stage 2: operands
    logic                     s2_v_reg;
    logic [ADDR_W-1:0]        p2_reg;
    logic                     int2_reg;
    logic signed [DATA_W-1:0] op_c_reg, op_pv_reg;
    logic signed [NSUM_W-1:0] op_n_reg, op_n_next;

    // stage 3: products
    logic                     s3_v_reg;
    logic [ADDR_W-1:0]        p3_reg;
    logic                     int3_reg;
    logic signed [DATA_W-1:0] c3_reg;
    logic signed [PROD_W-1:0] prod_c_reg, prod_n_reg, pvs_reg;
    logic signed [PROD_W-1:0] prod_c_next, prod_n_next, pvs_next;
    logic signed [CC_W:0]     cc_s;
    logic signed [NC_W:0]     nc_s;

    // stage 4: rounded, saturated result
    logic                     s4_v_reg;
    logic [ADDR_W-1:0]        p4_reg;
    logic                     int4_reg;
    logic signed [DATA_W-1:0] c4_reg, res4_reg;
    logic signed [ACC_W-1:0]  acc, q;
    logic                     ovf_hi, ovf_lo;
    logic signed [DATA_W-1:0] res_next;
    logic                     sat_reg;

    assign half   = (func_reg == FUNC_START);
    assign idx_ok = (32'(idx_reg) < MAX_POINTS);
    assign n_eff  = (32'(num_points) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(num_points);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg  <= in_func;
            idx_reg   <= in_idx;
            value_reg <= in_value;
        end
    end

    // memory reads
    assign rd_en   = cmd.rd_issue || cmd.sweep_issue;
    assign rd_addr = cmd.sweep_issue ? cmd.sweep_idx[ADDR_W-1:0] : ADDR_W'(idx_reg);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            cur_rd_reg      <= cur_mem[rd_addr];
            prev_rd_reg     <= prev_mem[rd_addr];
            cur_rd_vld_reg  <= cur_vld_reg[rd_addr];
            prev_rd_vld_reg <= prev_vld_reg[rd_addr];
        end
    end

    // memory writes
    assign cur_we = (cmd.load_wr && idx_ok) || s4_v_reg;
    assign cur_wa = s4_v_reg ? p4_reg : ADDR_W'(idx_reg);
    assign cur_wd = s4_v_reg ? (int4_reg ? res4_reg : '0) : value_reg;

    always_ff @(posedge aclk) begin
        if (cur_we) begin
            cur_mem[cur_wa] <= cur_wd;
        end
        if (s4_v_reg) begin
            prev_mem[p4_reg] <= int4_reg ? c4_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_vld_reg  <= '0;
            prev_vld_reg <= '0;
        end else begin
            if (cur_we) begin
                cur_vld_reg[cur_wa] <= 1'b1;
            end
            if (s4_v_reg) begin
                prev_vld_reg[p4_reg] <= 1'b1;
            end
        end
    end

    // stage 1
    assign rd_cur  = cur_rd_vld_reg  ? cur_rd_reg  : '0;
    assign rd_prev = prev_rd_vld_reg ? prev_rd_reg : '0;
    assign p1      = ADDR_W'(s1_j_reg - 1'b1);
    assign int1    = (p1 != '0) && ((CNT_W + 1)'(p1) + 2'd2 <= (CNT_W + 1)'(n_eff));

    always_comb begin
        if (half) begin
            op_n_next = NSUM_W'(rd_cur) + NSUM_W'(w2_reg) - (NSUM_W'(w1_reg) <<< 1);
        end else begin
            op_n_next = NSUM_W'(rd_cur) + NSUM_W'(w2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_v_reg) begin
            w2_reg  <= w1_reg;
            w1_reg  <= rd_cur;
            pv1_reg <= rd_prev;
        end
        op_c_reg  <= w1_reg;
        op_pv_reg <= pv1_reg;
        op_n_reg  <= op_n_next;
        p2_reg    <= p1;
        int2_reg  <= int1;
    end

    // stage 2 -> 3: multiplies
    assign cc_s = $signed({1'b0, center_coef});
    assign nc_s = $signed({1'b0, neighbor_coef});

    always_comb begin
        prod_n_next = PROD_W'(nc_s * op_n_reg);
        if (half) begin
            prod_c_next = PROD_W'(op_c_reg) <<< (FRAC_BITS + 1);
            pvs_next    = '0;
        end else begin
            prod_c_next = PROD_W'(cc_s * op_c_reg);
            pvs_next    = PROD_W'(op_pv_reg) <<< FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        prod_c_reg <= prod_c_next;
        prod_n_reg <= prod_n_next;
        pvs_reg    <= pvs_next;
        c3_reg     <= op_c_reg;
        p3_reg     <= p2_reg;
        int3_reg   <= int2_reg;
    end

    // stage 3 -> 4: sum, round, shift, saturate
    always_comb begin
        acc    = ACC_W'(prod_c_reg) + ACC_W'(prod_n_reg) - ACC_W'(pvs_reg);
        q      = half ? (acc + (ACC_W'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1)
                      : (acc + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        ovf_hi = !q[ACC_W-1] && (q[ACC_W-2:DATA_W-1] != '0);
        ovf_lo = q[ACC_W-1] && (q[ACC_W-2:DATA_W-1] != '1);
        if (ovf_hi) begin
            res_next = {1'b0, {(DATA_W - 1){1'b1}}};
        end else if (ovf_lo) begin
            res_next = {1'b1, {(DATA_W - 1){1'b0}}};
        end else begin
            res_next = q[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        res4_reg <= res_next;
        c4_reg   <= c3_reg;
        p4_reg   <= p3_reg;
        int4_reg <= int3_reg;
    end

    // pipeline tokens and saturation flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s1_j_reg <= '0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end else begin
            s1_v_reg <= cmd.sweep_issue;
            s1_j_reg <= cmd.sweep_idx;
            s2_v_reg <= s1_v_reg && (s1_j_reg != '0);
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            if (cmd.capture) begin
                sat_reg <= 1'b0;
            end else if (s3_v_reg && int3_reg && (ovf_hi || ovf_lo)) begin
                sat_reg <= 1'b1;
            end
        end
    end

    assign status.pipe_busy = s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg;
    assign status.sat       = sat_reg;
    assign res_value = ((func_reg == FUNC_READ) && idx_ok && cur_rd_vld_reg) ? cur_rd_reg : '0;

endmodule

>>> rtl/core/string_wave_stencil_step.sv
// Top level of the string wave stencil step block: config registers, output register.
// Depends on sws_pkg, sws_ctrl and sws_datapath.
//
// Fixed-end string solver with previous and current displacement arrays (signed Q8.24,
// MAX_POINTS entries each). A load or a read goes from acceptance through its load or read
// state to the result state; a start or time step sweeps every array entry, one point per
// cycle through two shared multipliers and the stencil pipeline. The sweep length is set
// by the one read port of each shape memory. The next item is accepted while an earlier
// result still waits in the output register. The user must write the configuration
// registers only while the block is idle; the block itself does not enforce this.
module string_wave_stencil_step
    import sws_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // point_index[5:0], point_value[37:6], zero pad
    input  logic [1:0]            s_tuser,   // func[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata    // read_value[31:0], saturated[32], zero pad
);

    logic [CC_W-1:0]          center_coef_reg;
    logic [NC_W-1:0]          neighbor_coef_reg;
    logic [NP_W-1:0]          num_points_reg;

    logic                     m_tvalid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_sat_reg;
    logic                     out_free;

    sws_cmd_t                 cmd;
    sws_status_t              status;
    func_t                    in_func;
    logic signed [DATA_W-1:0] res_value;

    assign in_func = func_t'(s_tuser);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_coef_reg   <= CENTER_COEF_RST;
            neighbor_coef_reg <= NEIGHBOR_COEF_RST;
            num_points_reg    <= NUM_POINTS_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_CENTER_COEF:   center_coef_reg   <= cfg_wdata[CC_W-1:0];
                REG_NEIGHBOR_COEF: neighbor_coef_reg <= cfg_wdata[NC_W-1:0];
                REG_NUM_POINTS:    num_points_reg    <= cfg_wdata[NP_W-1:0];
                default: ;
            endcase
        end
    end

    sws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_func  (in_func),
        .out_free (out_free),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    sws_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_func       (in_func),
        .in_idx        (s_tdata[PIDX_W-1:0]),
        .in_value      (s_tdata[PIDX_W+DATA_W-1:PIDX_W]),
        .center_coef   (center_coef_reg),
        .neighbor_coef (neighbor_coef_reg),
        .num_points    (num_points_reg),
        .status        (status),
        .res_value     (res_value)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_value_reg <= res_value;
            out_sat_reg   <= status.sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, out_sat_reg, out_value_reg};

endmodule
